### src/gntc_pkg.sv
`timescale 1ns / 1ps
package gntc_pkg;

  // sizing
  localparam int NumTemplatesDef = 5;
  localparam int PosW            = 4;
  localparam int AxisW           = 16;
  localparam int DistW           = 19;

  // configuration reset values
  localparam logic [11:0] GripThresholdReset = 12'd124;
  localparam logic [15:0] CooldownReset      = 16'd1500;

  // configuration register indexes
  localparam logic [1:0] CFG_GRIP_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_COOLDOWN_MS    = 2'd1;

  // input kinds
  localparam logic KIND_STORE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  // result status codes
  localparam logic [2:0] STATUS_NOT_READY = 3'd0;
  localparam logic [2:0] STATUS_GRIP_OPEN = 3'd1;
  localparam logic [2:0] STATUS_COOLING   = 3'd2;
  localparam logic [2:0] STATUS_FIRED     = 3'd3;
  localparam logic [2:0] STATUS_STORED    = 3'd4;

  // media action codes
  localparam logic [2:0] ACTION_NONE       = 3'd0;
  localparam logic [2:0] ACTION_NEXT_TRACK = 3'd1;
  localparam logic [2:0] ACTION_VOL_UP     = 3'd2;
  localparam logic [2:0] ACTION_VOL_DOWN   = 3'd3;
  localparam logic [2:0] ACTION_PLAY_PAUSE = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // sample word travelling down the cell chain with the running best match
  typedef struct packed {
    logic                    valid;
    logic signed [AxisW-1:0] ax;
    logic signed [AxisW-1:0] ay;
    logic signed [AxisW-1:0] az;
    logic [DistW-1:0]        best_d;
    logic [PosW-1:0]         best_pos;
  } tok_t;

  // action code for a winning slot
  function automatic logic [2:0] action_of(input logic [PosW-1:0] pos);
    logic [2:0] act;
    case (pos)
      4'd1:    act = ACTION_NEXT_TRACK;
      4'd2:    act = ACTION_VOL_UP;
      4'd3:    act = ACTION_VOL_DOWN;
      4'd4:    act = ACTION_PLAY_PAUSE;
      default: act = ACTION_NONE;
    endcase
    return act;
  endfunction

  // key repeat count for an action code
  function automatic logic [1:0] repeat_of(input logic [2:0] act);
    logic [1:0] rep;
    case (act)
      ACTION_NEXT_TRACK, ACTION_PLAY_PAUSE: rep = 2'd1;
      ACTION_VOL_UP, ACTION_VOL_DOWN:       rep = 2'd2;
      default:                              rep = 2'd0;
    endcase
    return rep;
  endfunction

endpackage

### src/gntc_cell.sv
`timescale 1ns / 1ps
module gntc_cell import gntc_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    store_en,
  input  logic [2:0]              store_slot,
  input  logic signed [AxisW-1:0] store_x,
  input  logic signed [AxisW-1:0] store_y,
  input  logic signed [AxisW-1:0] store_z,
  input  tok_t                    tok_in,
  output tok_t                    tok_out
);

  localparam logic [PosW-1:0] Idx = PosW'(INDEX);

  logic signed [AxisW-1:0] tx;
  logic signed [AxisW-1:0] ty;
  logic signed [AxisW-1:0] tz;
  logic signed [AxisW:0]   dx;
  logic signed [AxisW:0]   dy;
  logic signed [AxisW:0]   dz;
  logic [AxisW-1:0]        adx;
  logic [AxisW-1:0]        ady;
  logic [AxisW-1:0]        adz;
  logic [DistW-1:0]        l1_dist;
  logic                    take;

  // template storage for this slot
  always_ff @(posedge clk) begin
    if (store_en && ({1'b0, store_slot} == Idx)) begin
      tx <= store_x;
      ty <= store_y;
      tz <= store_z;
    end
  end

  // l1 distance from the passing sample to this template
  always_comb begin
    dx   = {tok_in.ax[AxisW-1], tok_in.ax} - {tx[AxisW-1], tx};
    dy   = {tok_in.ay[AxisW-1], tok_in.ay} - {ty[AxisW-1], ty};
    dz   = {tok_in.az[AxisW-1], tok_in.az} - {tz[AxisW-1], tz};
    adx  = dx[AxisW] ? AxisW'(-dx) : AxisW'(dx);
    ady  = dy[AxisW] ? AxisW'(-dy) : AxisW'(dy);
    adz  = dz[AxisW] ? AxisW'(-dz) : AxisW'(dz);
    l1_dist = DistW'(adx) + DistW'(ady) + DistW'(adz);
    // strict compare keeps the lower slot on a tie
    take = l1_dist < tok_in.best_d;
  end

  // hand the word on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.ax       <= tok_in.ax;
    tok_out.ay       <= tok_in.ay;
    tok_out.az       <= tok_in.az;
    tok_out.best_d   <= take ? l1_dist : tok_in.best_d;
    tok_out.best_pos <= take ? Idx : tok_in.best_pos;
  end

endmodule

### src/gated_nearest_template_classifier_unit.sv
`timescale 1ns / 1ps
// flow: a stored template or a gated sample goes through the pending result register
// and then the output register, which it enters once the output is free; a fired sample
// first walks the chain of NUM_TEMPLATES cells, one a cycle, then takes the same two registers
// intake: no new word is accepted until the last result has moved to the output register
// reset: synchronous, clears slot flags, last fire time, handshakes and config to defaults
module gated_nearest_template_classifier_unit import gntc_pkg::*; #(
  parameter int NUM_TEMPLATES = NumTemplatesDef
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    kind,
  input  logic [2:0]              slot,
  input  logic signed [AxisW-1:0] accel_x,
  input  logic signed [AxisW-1:0] accel_y,
  input  logic signed [AxisW-1:0] accel_z,
  input  logic [11:0]             grip_level,
  input  logic [31:0]             now_ms,
  input  logic                    link_up,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [2:0]              position,
  output logic [2:0]              action,
  output logic [1:0]              repeat_res,
  output logic [DistW-1:0]        best_distance,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  state_t state;
  state_t state_next;

  logic [11:0]              grip_threshold;
  logic [15:0]              cooldown_ms;
  logic [NUM_TEMPLATES-1:0] slot_written;
  logic [NUM_TEMPLATES-1:0] slot_written_next;
  logic [31:0]              last_fire_time;

  logic        in_accept;
  logic        store_ok;
  logic        fire;
  logic [31:0] since;
  logic [2:0]  gate_status;
  logic        load_gate;
  logic        load_chain;
  logic        load_out;

  logic [2:0]       res_status;
  logic [2:0]       res_position;
  logic [2:0]       res_action;
  logic [1:0]       res_repeat;
  logic [DistW-1:0] res_dist;
  logic [2:0]       chain_action;

  tok_t                     chain [NUM_TEMPLATES+1];
  logic [NUM_TEMPLATES-1:0] cell_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grip_threshold <= GripThresholdReset;
      cooldown_ms    <= CooldownReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRIP_THRESHOLD: grip_threshold <= cfg_data[11:0];
        CFG_COOLDOWN_MS:    cooldown_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // gating decision on the incoming word
  always_comb begin
    store_ok = (kind == KIND_STORE) && ({2'b00, slot} < 5'(NUM_TEMPLATES));
    since    = now_ms - last_fire_time;
    if (kind == KIND_STORE) begin
      gate_status = store_ok ? STATUS_STORED : STATUS_NOT_READY;
    end else if (!(&slot_written) || !link_up) begin
      gate_status = STATUS_NOT_READY;
    end else if (grip_level <= grip_threshold) begin
      gate_status = STATUS_GRIP_OPEN;
    end else if (since < {16'd0, cooldown_ms}) begin
      gate_status = STATUS_COOLING;
    end else begin
      gate_status = STATUS_FIRED;
    end
    fire = in_accept && (gate_status == STATUS_FIRED);
  end

  // slot written flags
  always_comb begin
    for (int i = 0; i < NUM_TEMPLATES; i++) begin
      slot_written_next[i] = slot_written[i] ||
                             (in_accept && store_ok && ({2'b00, slot} == 5'(i)));
    end
  end

  // launch word into the first cell
  always_comb begin
    chain[0].valid    = fire;
    chain[0].ax       = accel_x;
    chain[0].ay       = accel_y;
    chain[0].az       = accel_z;
    chain[0].best_d   = '1;
    chain[0].best_pos = '0;
  end

  // one cell per template slot
  for (genvar g = 0; g < NUM_TEMPLATES; g++) begin : g_cell
    gntc_cell #(
      .INDEX(g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .store_en  (in_accept && store_ok),
      .store_slot(slot),
      .store_x   (accel_x),
      .store_y   (accel_y),
      .store_z   (accel_z),
      .tok_in    (chain[g]),
      .tok_out   (chain[g+1])
    );
    assign cell_valid[g] = chain[g+1].valid;
  end

  assign chain_action = action_of(chain[NUM_TEMPLATES].best_pos);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and load strobes
  always_comb begin
    state_next = state;
    load_gate  = 1'b0;
    load_chain = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (fire) begin
          state_next = ST_SCAN;
        end else if (in_accept) begin
          load_gate  = 1'b1;
          state_next = ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (chain[NUM_TEMPLATES].valid) begin
          load_chain = 1'b1;
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_written   <= '0;
      last_fire_time <= '0;
    end else begin
      slot_written <= slot_written_next;
      if (fire) begin
        last_fire_time <= now_ms;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (load_gate) begin
      res_status   <= gate_status;
      res_position <= 3'd0;
      res_action   <= ACTION_NONE;
      res_repeat   <= 2'd0;
      res_dist     <= '0;
    end else if (load_chain) begin
      res_status   <= STATUS_FIRED;
      res_position <= chain[NUM_TEMPLATES].best_pos[2:0];
      res_action   <= chain_action;
      res_repeat   <= repeat_of(chain_action);
      res_dist     <= chain[NUM_TEMPLATES].best_d;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      status        <= res_status;
      position      <= res_position;
      action        <= res_action;
      repeat_res    <= res_repeat;
      best_distance <= res_dist;
    end
  end

`ifndef SYNTHESIS
  // at most one sample in the chain at a time
  a_chain_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid))
    else $error("more than one sample in the cell chain");

  // chain words only appear while scanning
  a_chain_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_TEMPLATES].valid |-> (state == ST_SCAN))
    else $error("chain output outside scan");

  // a fired sample records its time
  a_fire_time: assert property (@(posedge clk) disable iff (rst)
    fire |=> (last_fire_time == $past(now_ms)))
    else $error("last fire time not recorded");

  // a fired result carries a real distance
  a_fire_dist: assert property (@(posedge clk) disable iff (rst)
    load_chain |=> (res_status == STATUS_FIRED) && (res_dist <= 19'd196605))
    else $error("fired distance out of range");

  // nothing is accepted while a result is pending
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) && out_valid && out_stall |=> (state == ST_HOLD) && !$past(in_accept))
    else $error("result dropped while output stalled");
`endif

endmodule

### verif/gntc_checker.sv
`timescale 1ns / 1ps
module gntc_checker import gntc_pkg::*; #(
  parameter int NUM_TEMPLATES = NumTemplatesDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    kind,
  input  logic [2:0]              slot,
  input  logic signed [AxisW-1:0] accel_x,
  input  logic signed [AxisW-1:0] accel_y,
  input  logic signed [AxisW-1:0] accel_z,
  input  logic [11:0]             grip_level,
  input  logic [31:0]             now_ms,
  input  logic                    link_up,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [2:0]              status,
  input  logic [2:0]              position,
  input  logic [2:0]              action,
  input  logic [1:0]              repeat_res,
  input  logic [DistW-1:0]        best_distance,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  output int                      mismatches,
  output int                      words_due
);

  // one predicted output word
  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       position;
    logic [2:0]       action;
    logic [1:0]       repeat_res;
    logic [DistW-1:0] best_distance;
  } gesture_t;

  gesture_t gestures_due[$];

  // shadow of the block state and its registers
  logic signed [AxisW-1:0]  tpl_x [NUM_TEMPLATES];
  logic signed [AxisW-1:0]  tpl_y [NUM_TEMPLATES];
  logic signed [AxisW-1:0]  tpl_z [NUM_TEMPLATES];
  logic [NUM_TEMPLATES-1:0] tpl_seen;
  logic [31:0]              last_fire;
  logic [11:0]              grip_thr;
  logic [15:0]              cool_ms;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int axis_gap(input logic signed [AxisW-1:0] a,
                                  input logic signed [AxisW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // gate the sample, then scan the templates for the smallest l1 distance
  task automatic judge_word(input logic k, input logic [2:0] s,
                            input logic signed [AxisW-1:0] ax,
                            input logic signed [AxisW-1:0] ay,
                            input logic signed [AxisW-1:0] az,
                            input logic [11:0] grip, input logic [31:0] now,
                            input logic lnk, output gesture_t g);
    int best;
    int d;
    int pick;
    logic [31:0] elapsed;
    g = '0;
    elapsed = now - last_fire;
    if (k == KIND_STORE) begin
      // out of range slots fall through with an all-zero word
      if (s < NUM_TEMPLATES) begin
        tpl_x[s] = ax;
        tpl_y[s] = ay;
        tpl_z[s] = az;
        tpl_seen[s] = 1'b1;
        g.status = STATUS_STORED;
      end
    end else if (!(&tpl_seen) || !lnk) begin
      g.status = STATUS_NOT_READY;
    end else if (grip <= grip_thr) begin
      g.status = STATUS_GRIP_OPEN;
    end else if (elapsed < {16'd0, cool_ms}) begin
      g.status = STATUS_COOLING;
    end else begin
      best = 32'h7fff_ffff;
      pick = 0;
      // strict compare keeps the lowest slot on a tie
      for (int i = 0; i < NUM_TEMPLATES; i++) begin
        d = axis_gap(ax, tpl_x[i]) + axis_gap(ay, tpl_y[i]) + axis_gap(az, tpl_z[i]);
        if (d < best) begin
          best = d;
          pick = i;
        end
      end
      case (pick)
        1: begin
          g.action = ACTION_NEXT_TRACK;
          g.repeat_res = 2'd1;
        end
        2: begin
          g.action = ACTION_VOL_UP;
          g.repeat_res = 2'd2;
        end
        3: begin
          g.action = ACTION_VOL_DOWN;
          g.repeat_res = 2'd2;
        end
        4: begin
          g.action = ACTION_PLAY_PAUSE;
          g.repeat_res = 2'd1;
        end
        default: begin
          g.action = ACTION_NONE;
          g.repeat_res = 2'd0;
        end
      endcase
      g.position = 3'(pick);
      g.best_distance = DistW'(best);
      g.status = STATUS_FIRED;
      last_fire = now;
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin : watch
    gesture_t want;
    gesture_t fresh;
    if (rst) begin
      gestures_due.delete();
      tpl_seen = '0;
      last_fire = '0;
      grip_thr = GripThresholdReset;
      cool_ms = CooldownReset;
      mismatches = 0;
      words_due <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRIP_THRESHOLD: grip_thr = cfg_data[11:0];
          CFG_COOLDOWN_MS:    cool_ms = cfg_data;
          default: ;
        endcase
      end
      // output word against the oldest prediction
      if (out_valid && !out_stall) begin
        if (gestures_due.size() == 0) begin
          flag_mismatch("word with nothing pending, status", status, 0);
        end else begin
          want = gestures_due.pop_front();
          if (status !== want.status) flag_mismatch("status", status, want.status);
          if (position !== want.position) flag_mismatch("position", position, want.position);
          if (action !== want.action) flag_mismatch("action", action, want.action);
          if (repeat_res !== want.repeat_res)
            flag_mismatch("repeat_res", repeat_res, want.repeat_res);
          if (best_distance !== want.best_distance)
            flag_mismatch("best_distance", best_distance, want.best_distance);
        end
      end
      // input word into the predictor
      if (in_valid && !in_stall) begin
        judge_word(kind, slot, accel_x, accel_y, accel_z, grip_level, now_ms, link_up, fresh);
        gestures_due.push_back(fresh);
      end
      words_due <= gestures_due.size();
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import gntc_pkg::*;

  localparam int NUM_TEMPLATES = NumTemplatesDef;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE        = NUM_TEMPLATES + 4;
  localparam int HOLD_CYCLES   = 80;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    kind = 1'b0;
  logic [2:0]              slot = '0;
  logic signed [AxisW-1:0] accel_x = '0;
  logic signed [AxisW-1:0] accel_y = '0;
  logic signed [AxisW-1:0] accel_z = '0;
  logic [11:0]             grip_level = '0;
  logic [31:0]             now_ms = '0;
  logic                    link_up = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [2:0]              status;
  logic [2:0]              position;
  logic [2:0]              action;
  logic [1:0]              repeat_res;
  logic [DistW-1:0]        best_distance;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [15:0]             cfg_data = '0;

  int mismatches;
  int words_due;

  // stall and gap control
  logic fast = 1'b0;
  int   hold_asked = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   rx_wait = 0;
  int   quiet = 0;

  // what the stimulus knows of the stored templates and the settings
  int          shadow_x [NUM_TEMPLATES];
  int          shadow_y [NUM_TEMPLATES];
  int          shadow_z [NUM_TEMPLATES];
  logic [31:0] clock_ms = '0;
  logic [11:0] thr_now = GripThresholdReset;
  logic [15:0] cool_now = CooldownReset;

  gated_nearest_template_classifier_unit #(
    .NUM_TEMPLATES(NUM_TEMPLATES)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .slot(slot),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .grip_level(grip_level), .now_ms(now_ms), .link_up(link_up),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .position(position),
    .action(action), .repeat_res(repeat_res), .best_distance(best_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gntc_checker #(
    .NUM_TEMPLATES(NUM_TEMPLATES)
  ) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .slot(slot),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .grip_level(grip_level), .now_ms(now_ms), .link_up(link_up),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .position(position),
    .action(action), .repeat_res(repeat_res), .best_distance(best_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .words_due(words_due)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stall per word, plus a long hold-off on request
  always @(posedge clk) begin : rx
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (out_valid && !out_stall) begin
      n = fast ? 0 : $urandom_range(0, 4);
      rx_wait <= n;
      out_stall <= (n != 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int rail_value();
    case ($urandom_range(0, 2))
      0:       return -32768;
      1:       return 32767;
      default: return 0;
    endcase
  endfunction

  // offer one word after a random gap and hold it until taken
  task automatic offer_word(input logic k, input logic [2:0] s, input int x, input int y,
                            input int z, input int grip, input logic [31:0] now,
                            input logic lnk);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    slot <= s;
    accel_x <= 16'(x);
    accel_y <= 16'(y);
    accel_z <= 16'(z);
    grip_level <= 12'(grip);
    now_ms <= now;
    link_up <= lnk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == KIND_STORE && s < NUM_TEMPLATES) begin
      shadow_x[s] = x;
      shadow_y[s] = y;
      shadow_z[s] = z;
    end
  endtask

  // stop offering and let every pending word come out
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly live samples near stored templates, some stores and noise
  task automatic random_word();
    int r;
    int k;
    int x;
    int y;
    int z;
    int grip;
    logic [2:0] s;
    logic lnk;
    r = $urandom_range(0, 99);
    if (r < 13) begin
      s = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(0, NUM_TEMPLATES - 1))
                                       : 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) begin
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
        z = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        x = int'($urandom_range(0, 4000)) - 2000;
        y = int'($urandom_range(0, 4000)) - 2000;
        z = int'($urandom_range(0, 4000)) - 2000;
      end
      offer_word(KIND_STORE, s, x, y, z, $urandom_range(0, 4095), $urandom,
                 1'($urandom_range(0, 1)));
    end else begin
      // accel: near a template, anywhere, or on the rails
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k = $urandom_range(0, NUM_TEMPLATES - 1);
        x = clip(shadow_x[k] + int'($urandom_range(0, 600)) - 300, -32768, 32767);
        y = clip(shadow_y[k] + int'($urandom_range(0, 600)) - 300, -32768, 32767);
        z = clip(shadow_z[k] + int'($urandom_range(0, 600)) - 300, -32768, 32767);
      end else if (r < 85) begin
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
        z = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        x = rail_value();
        y = rail_value();
        z = rail_value();
      end
      // grip anywhere or around the threshold
      if ($urandom_range(0, 99) < 60) grip = $urandom_range(0, 4095);
      else grip = clip(int'(thr_now) + int'($urandom_range(0, 4)) - 2, 0, 4095);
      // millisecond clock mostly moves forward, sometimes jumps or nears the wrap
      r = $urandom_range(0, 99);
      if (r < 70) clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(cool_now) + 100));
      else if (r < 85) clock_ms = clock_ms + 32'($urandom_range(0, 100));
      else if (r < 95) clock_ms = $urandom;
      else clock_ms = 32'hffff_ffff - 32'($urandom_range(0, 3000));
      lnk = ($urandom_range(0, 99) < 92);
      offer_word(KIND_CLASSIFY, 3'($urandom_range(0, 7)), x, y, z, grip, clock_ms, lnk);
    end
  endtask

  initial begin
    int quota [6];
    logic [3:0] hi;
    quota = '{60, 110, 40, 120, 120, 100};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: gating order, slot range, rails, ties and clock wrap
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 4095, 32'd5000, 1'b1);
    offer_word(KIND_STORE, 3'd7, -32768, 32767, -1, 0, 32'd0, 1'b0);
    offer_word(KIND_STORE, 3'd5, 1, 2, 3, 4095, 32'hffff_ffff, 1'b1);
    offer_word(KIND_STORE, 3'd0, 0, 0, 0, 0, 32'd0, 1'b1);
    offer_word(KIND_STORE, 3'd1, 32767, 32767, 32767, 0, 32'd0, 1'b1);
    offer_word(KIND_STORE, 3'd2, -32768, -32768, -32768, 0, 32'd0, 1'b1);
    offer_word(KIND_STORE, 3'd3, 1000, -1000, 0, 0, 32'd0, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 4095, 32'd5000, 1'b1);
    offer_word(KIND_STORE, 3'd4, -1000, 1000, 0, 0, 32'd0, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 4095, 32'd5000, 1'b0);
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 124, 32'd5000, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 0, 32'd5000, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 125, 32'd1499, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 32767, 32767, 32767, 125, 32'd1500, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, -32768, -32768, -32768, 4095, 32'd2999, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, -32768, -32768, -32767, 4095, 32'd3000, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 500, -500, 0, 4095, 32'd4500, 1'b1);
    offer_word(KIND_STORE, 3'd4, 1000, -1000, 0, 0, 32'd0, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 900, -900, 0, 4095, 32'd6000, 1'b1);
    offer_word(KIND_STORE, 3'd4, -1000, 1000, 0, 0, 32'd0, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, -1200, 1100, 50, 4095, 32'hffff_ff00, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 0, 0, 0, 4095, 32'h0000_0010, 1'b1);
    offer_word(KIND_CLASSIFY, 3'd0, 32767, -32768, 32767, 4095, 32'h0000_0600, 1'b1);
    clock_ms = 32'h0000_0600;

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          thr_now = 12'd0;
          cool_now = 16'd0;
        end
        2: begin
          thr_now = 12'd4095;
          cool_now = 16'd0;
        end
        3: begin
          thr_now = 12'd0;
          cool_now = 16'hffff;
        end
        4: begin
          thr_now = 12'($urandom_range(0, 4095));
          cool_now = 16'($urandom_range(0, 65535));
        end
        5: begin
          thr_now = GripThresholdReset;
          cool_now = CooldownReset;
        end
        default: ;
      endcase
      if (ph != 0) begin
        drain_block();
        // upper data bits do not belong to the threshold
        hi = (ph == 4) ? 4'($urandom) : 4'd0;
        set_register(CFG_GRIP_THRESHOLD, {hi, thr_now});
        set_register(CFG_COOLDOWN_MS, cool_now);
      end
      if (ph == 1 || ph == 3) hold_asked <= hold_asked + 1;
      for (int i = 0; i < quota[ph]; i++) begin
        fast <= (i < 25);
        random_word();
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
src/gntc_pkg.sv
src/gntc_cell.sv
src/gated_nearest_template_classifier_unit.sv
verif/gntc_checker.sv
verif/tb.sv
